[src/led_pixel_frame_serializer_defines.svh]
// Assertion macros used by the LED pixel frame serializer RTL.
// Requires clk and rst_n in the scope of every use.
`ifndef LED_PIXEL_FRAME_SERIALIZER_DEFINES_SVH
`define LED_PIXEL_FRAME_SERIALIZER_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define LPF_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define LPF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[src/lpf_pkg.sv]
// Package for the LED pixel frame serializer: sizes, codes, payload types
// and the brightness bit-select function. No dependencies.
`timescale 1ns / 1ps

package lpf_pkg;

    localparam int MAX_PIXELS     = 256;
    localparam int ADDR_W         = $clog2(MAX_PIXELS);
    localparam int LEN_W          = 9;
    localparam int LVL_W          = 3;
    localparam int PIX_W          = 16;
    localparam int POS_W          = 8;
    localparam int START_BITS     = 32;
    localparam int BITS_PER_PIXEL = 16;
    localparam int BITCUR_W       = $clog2(START_BITS);
    localparam int CFG_DATA_W     = 9;
    localparam int CFG_IDX_W      = 1;

    localparam logic [PIX_W-1:0] PIXEL_RESET  = 16'h8000;
    localparam logic [LVL_W-1:0] LEVEL_FULL   = 3'd5;
    localparam logic [LEN_W-1:0] LEN_RESET    = LEN_W'(MAX_PIXELS);

    typedef enum logic [1:0] {
        REQ_SET   = 2'd0,
        REQ_FILL  = 2'd1,
        REQ_START = 2'd2,
        REQ_TICK  = 2'd3
    } req_type_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_STRIP_LENGTH = 1'b0,
        CFG_GLOBAL_LEVEL = 1'b1
    } cfg_index_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FILL,
        ST_READ
    } lpf_state_t;

    typedef struct packed {
        logic [1:0]       req_type;
        logic [POS_W-1:0] position;
        logic [PIX_W-1:0] pixel_word;
    } lpf_req_t;

    typedef struct packed {
        logic data_bit;
        logic bit_valid;
        logic frame_last;
        logic busy_res;
        logic rejected;
    } lpf_res_t;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] addr;
        logic [PIX_W-1:0]  data;
    } lpf_mem_wr_t;

    typedef struct packed {
        logic idle;
        logic res_load;
    } lpf_ctrl_status_t;

    // Bit idx (0 = first sent) of pixel word w at brightness lvl.
    // Channel bits beyond the kept top lvl bits go out as zeros.
    function automatic logic level_bit(logic [PIX_W-1:0] w, logic [3:0] idx,
                                       logic [LVL_W-1:0] lvl);
        logic [3:0]       base;
        logic [2:0]       p;
        logic [3:0]       sum;
        logic [3:0]       src;
        logic [LVL_W-1:0] l;
        l = (lvl > LEVEL_FULL) ? LEVEL_FULL : lvl;
        if (idx <= 4'd5) begin
            base = 4'd0;
            p    = 3'(idx - 4'd1);
        end
        else if (idx <= 4'd10) begin
            base = 4'd5;
            p    = 3'(idx - 4'd6);
        end
        else begin
            base = 4'd10;
            p    = 3'(idx - 4'd11);
        end
        sum = 4'(p) + 4'(l);
        src = 4'd14 - base - (sum - 4'd5);
        if (idx == 4'd0)
            return w[PIX_W-1];
        else if (sum < 4'd5)
            return 1'b0;
        else
            return w[src];
    endfunction

endpackage

[src/lpf_pixel_mem.sv]
// Pixel word store: one write port, one registered read port.
// Per-entry valid bits make unwritten entries read as the reset word. Uses lpf_pkg.
`timescale 1ns / 1ps

module lpf_pixel_mem (
    input  logic                              clk,
    input  logic                              rst_n,
    input  lpf_pkg::lpf_mem_wr_t              wr,
    input  logic [lpf_pkg::ADDR_W-1:0]        rd_addr,
    output logic [lpf_pkg::PIX_W-1:0]         rd_data
);
    import lpf_pkg::*;

    logic [PIX_W-1:0]      mem [MAX_PIXELS];
    logic [MAX_PIXELS-1:0] entry_vld_reg;
    logic [PIX_W-1:0]      rd_word_reg;
    logic                  rd_vld_reg;

    always_ff @(posedge clk)
    begin
        if (wr.we)
        begin
            mem[wr.addr] <= wr.data;
        end
        rd_word_reg <= mem[rd_addr];
        rd_vld_reg  <= entry_vld_reg[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_vld_reg <= '0;
        end
        else if (wr.we)
        begin
            entry_vld_reg[wr.addr] <= 1'b1;
        end
    end

    assign rd_data = rd_vld_reg ? rd_word_reg : PIXEL_RESET;

endmodule

[src/lpf_frame_ctrl.sv]
// Request sequencer: set/fill/start/tick handling, frame cursors, fill sweep
// and pixel fetch. Uses lpf_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "led_pixel_frame_serializer_defines.svh"

module lpf_frame_ctrl (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          req_fire,
    input  lpf_pkg::lpf_req_t             req,
    input  logic [lpf_pkg::LEN_W-1:0]     len,
    input  logic [lpf_pkg::LVL_W-1:0]     level,
    output lpf_pkg::lpf_ctrl_status_t     status,
    output lpf_pkg::lpf_res_t             res,
    output lpf_pkg::lpf_mem_wr_t          mem_wr,
    output logic [lpf_pkg::ADDR_W-1:0]    mem_rd_addr,
    input  logic [lpf_pkg::PIX_W-1:0]     mem_rd_data
);
    import lpf_pkg::*;

    localparam logic [BITCUR_W-1:0] START_LAST = BITCUR_W'(START_BITS - 1);
    localparam logic [BITCUR_W-1:0] PIX_LAST   = BITCUR_W'(BITS_PER_PIXEL - 1);

    lpf_state_t          state_reg, state_next;
    logic                frame_active_reg, frame_active_next;
    logic                in_start_run_reg, in_start_run_next;
    logic [ADDR_W-1:0]   pixel_cursor_reg, pixel_cursor_next;
    logic [BITCUR_W-1:0] bit_cursor_reg, bit_cursor_next;
    logic [ADDR_W-1:0]   fill_idx_reg, fill_idx_next;
    logic [PIX_W-1:0]    fill_word_reg, fill_word_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            frame_active_reg <= 1'b0;
            in_start_run_reg <= 1'b0;
            pixel_cursor_reg <= '0;
            bit_cursor_reg   <= '0;
            fill_idx_reg     <= '0;
        end
        else
        begin
            state_reg        <= state_next;
            frame_active_reg <= frame_active_next;
            in_start_run_reg <= in_start_run_next;
            pixel_cursor_reg <= pixel_cursor_next;
            bit_cursor_reg   <= bit_cursor_next;
            fill_idx_reg     <= fill_idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        fill_word_reg <= fill_word_next;
    end

    // High on the frame's last pixel: at its end the frame closes, else the cursor moves on.
    logic pixel_is_last;
    assign pixel_is_last = (LEN_W'(pixel_cursor_reg) + LEN_W'(1)) >= len;

    always_comb
    begin
        state_next        = state_reg;
        frame_active_next = frame_active_reg;
        in_start_run_next = in_start_run_reg;
        pixel_cursor_next = pixel_cursor_reg;
        bit_cursor_next   = bit_cursor_reg;
        fill_idx_next     = fill_idx_reg;
        fill_word_next    = fill_word_reg;
        mem_wr            = '0;
        mem_rd_addr       = pixel_cursor_reg;
        res               = '0;
        status.res_load   = 1'b0;
        status.idle       = (state_reg == ST_IDLE);

        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_fire)
                begin
                    status.res_load = 1'b1;
                    unique case (req_type_t'(req.req_type))
                        REQ_SET:
                        begin
                            if (frame_active_reg || (LEN_W'(req.position) >= len))
                                res.rejected = 1'b1;
                            else
                            begin
                                mem_wr.we   = 1'b1;
                                mem_wr.addr = ADDR_W'(req.position);
                                mem_wr.data = req.pixel_word;
                            end
                        end
                        REQ_FILL:
                        begin
                            if (frame_active_reg)
                                res.rejected = 1'b1;
                            else
                            begin
                                status.res_load = 1'b0;
                                fill_idx_next   = '0;
                                fill_word_next  = req.pixel_word;
                                state_next      = ST_FILL;
                            end
                        end
                        REQ_START:
                        begin
                            if (frame_active_reg)
                                res.rejected = 1'b1;
                            else
                            begin
                                frame_active_next = 1'b1;
                                in_start_run_next = 1'b1;
                                pixel_cursor_next = '0;
                                bit_cursor_next   = '0;
                            end
                        end
                        REQ_TICK:
                        begin
                            if (frame_active_reg)
                            begin
                                if (in_start_run_reg)
                                begin
                                    res.bit_valid = 1'b1;
                                    if (bit_cursor_reg >= START_LAST)
                                    begin
                                        in_start_run_next = 1'b0;
                                        bit_cursor_next   = '0;
                                    end
                                    else
                                        bit_cursor_next = bit_cursor_reg + BITCUR_W'(1);
                                end
                                else
                                begin
                                    // pixel bit: wait in ST_READ for the registered store read
                                    status.res_load = 1'b0;
                                    state_next      = ST_READ;
                                end
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_FILL:
            begin
                mem_wr.we   = 1'b1;
                mem_wr.addr = fill_idx_reg;
                mem_wr.data = fill_word_reg;
                if ((LEN_W'(fill_idx_reg) + LEN_W'(1)) >= len)
                begin
                    status.res_load = 1'b1;
                    state_next      = ST_IDLE;
                end
                else
                    fill_idx_next = fill_idx_reg + ADDR_W'(1);
            end
            ST_READ:
            begin
                status.res_load = 1'b1;
                res.bit_valid   = 1'b1;
                res.data_bit    = level_bit(mem_rd_data, bit_cursor_reg[3:0], level);
                state_next      = ST_IDLE;
                if (bit_cursor_reg >= PIX_LAST)
                begin
                    bit_cursor_next = '0;
                    if (pixel_is_last)
                    begin
                        res.frame_last    = 1'b1;
                        frame_active_next = 1'b0;
                        pixel_cursor_next = '0;
                    end
                    else
                        pixel_cursor_next = pixel_cursor_reg + ADDR_W'(1);
                end
                else
                    bit_cursor_next = bit_cursor_reg + BITCUR_W'(1);
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        res.busy_res = frame_active_next;
    end

    `LPF_ASSERT_NOW(a_fill_not_in_frame, state_reg == ST_FILL, !frame_active_reg,
        "fill sweep running during a frame")
    `LPF_ASSERT_NOW(a_start_run_in_frame, in_start_run_reg, frame_active_reg,
        "start run flagged outside a frame")
    `LPF_ASSERT_NOW(a_last_closes_frame, status.res_load && res.frame_last,
        res.bit_valid && !res.busy_res && state_reg == ST_READ,
        "frame end without a pixel bit")
    `LPF_ASSERT_NEXT(a_read_returns, state_reg == ST_READ, state_reg == ST_IDLE,
        "pixel read did not finish in one cycle")

endmodule

[src/led_pixel_frame_serializer.sv]
// LED pixel frame serializer top: handshake, configuration registers,
// output register. Uses lpf_pkg, lpf_pixel_mem and lpf_frame_ctrl.
`timescale 1ns / 1ps
// Results: set, start, idle tick and start-run tick: result loaded into the output register on accept.
//   Pixel-bit tick: passes through ST_READ for the registered read of the pixel store.
//   Fill: ST_FILL writes one store entry per cycle up to the effective length, then loads the result.
// Throughput: one transaction per cycle while the result slot is free; pixel bits and fill hold it.
// Reset (rst_n, async, active low): idle, no frame, store reads 0x8000 everywhere,
//   strip_length 256, global_level full.

module led_pixel_frame_serializer (
    input  logic                              clk,
    input  logic                              rst_n,
    // request channel
    input  logic                              req_valid,
    output logic                              req_ready,
    input  lpf_pkg::lpf_req_t                 req,
    // result channel
    output logic                              res_valid,
    input  logic                              res_ready,
    output lpf_pkg::lpf_res_t                 res,
    // configuration write port
    input  logic                              cfg_we,
    input  logic [lpf_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [lpf_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import lpf_pkg::*;

    logic [LEN_W-1:0]  strip_length_reg;
    logic [LVL_W-1:0]  global_level_reg;
    logic [LEN_W-1:0]  eff_len;
    logic              req_fire;
    logic              res_valid_reg;
    lpf_res_t          res_reg;
    lpf_res_t          ctrl_res;
    lpf_ctrl_status_t  ctrl_status;
    lpf_mem_wr_t       mem_wr;
    logic [ADDR_W-1:0] mem_rd_addr;
    logic [PIX_W-1:0]  mem_rd_data;

    // Configuration registers; a level write takes cfg_data[2:0], and values above full saturate.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            strip_length_reg <= LEN_RESET;
            global_level_reg <= LEVEL_FULL;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_STRIP_LENGTH: strip_length_reg <= LEN_W'(cfg_data);
                CFG_GLOBAL_LEVEL:
                begin
                    if (cfg_data[LVL_W-1:0] > LEVEL_FULL)
                        global_level_reg <= LEVEL_FULL;
                    else
                        global_level_reg <= cfg_data[LVL_W-1:0];
                end
                default:
                begin
                end
            endcase
        end
    end

    // Effective length: zero acts as one, above the store depth clamps to it.
    always_comb
    begin
        if (strip_length_reg == '0)
            eff_len = LEN_W'(1);
        else if (strip_length_reg > LEN_W'(MAX_PIXELS))
            eff_len = LEN_W'(MAX_PIXELS);
        else
            eff_len = strip_length_reg;
    end

    // A new transaction is taken only by an idle sequencer whose result
    // slot is empty or draining this cycle, so every result has a place.
    assign req_ready = ctrl_status.idle && (!res_valid_reg || res_ready);
    assign req_fire  = req_valid && req_ready;

    lpf_frame_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_fire    (req_fire),
        .req         (req),
        .len         (eff_len),
        .level       (global_level_reg),
        .status      (ctrl_status),
        .res         (ctrl_res),
        .mem_wr      (mem_wr),
        .mem_rd_addr (mem_rd_addr),
        .mem_rd_data (mem_rd_data)
    );

    lpf_pixel_mem u_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (mem_wr),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    // Output register: holds a result until the consumer takes it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (ctrl_status.res_load)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (res_ready)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl_status.res_load)
        begin
            res_reg <= ctrl_res;
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule
